FILE: sv/svm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

  // Sample memory geometry: one region per sound, regions packed back to back
  localparam int unsigned SOUNDS      = 4;
  localparam int unsigned SOUND_WORDS = 16384;
  localparam int unsigned SND_W       = 2;   // bits of a sound number
  localparam int unsigned OFS_W       = 14;  // bits of an offset inside a region
  localparam int unsigned MEM_AW      = SND_W + OFS_W;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 9;
  localparam int unsigned POS_W    = 15;
  localparam int unsigned LEN_W    = 15;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W + 1;

  // Request kinds carried on tuser
  typedef enum logic [1:0] {
    REQ_TRIGGER = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_WRITE   = 2'd2
  } req_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic trig_en;
    logic write_en;
    logic clear_acc;
    logic issue_en;
    logic load_out;
  } svm_cmd_t;

endpackage

`default_nettype wire

FILE: sv/svm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module svm_ctrl #(
  parameter int unsigned VOICES = 4,
  parameter int unsigned VW     = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire logic [1:0]       req_type_i,
  output logic                  req_ready_o,
  input  wire logic             out_free_i,
  output svm_pkg::svm_cmd_t     cmd_o,
  output logic [VW-1:0]         voice_o
);

  svm_pkg::state_e state_q, state_d;
  logic [VW-1:0]   cnt_q, cnt_d;
  logic            last_voice;
  svm_pkg::req_e   req;

  assign req        = svm_pkg::req_e'(req_type_i);
  assign last_voice = (cnt_q == VW'(VOICES - 1));

  // Next state and voice counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      svm_pkg::ST_IDLE: begin
        if (req_valid_i && req == svm_pkg::REQ_TICK) begin
          state_d = svm_pkg::ST_MIX;
          cnt_d   = '0;
        end
      end
      svm_pkg::ST_MIX: begin
        if (last_voice) begin
          state_d = svm_pkg::ST_DRAIN1;
        end else begin
          cnt_d = cnt_q + VW'(1);
        end
      end
      svm_pkg::ST_DRAIN1: state_d = svm_pkg::ST_DRAIN2;
      svm_pkg::ST_DRAIN2: state_d = svm_pkg::ST_FINISH;
      svm_pkg::ST_FINISH: begin
        if (out_free_i) begin
          state_d = svm_pkg::ST_IDLE;
        end
      end
      default: state_d = svm_pkg::ST_IDLE;
    endcase
  end

  // Commands per state
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    voice_o     = cnt_q;
    case (state_q)
      svm_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (req)
            svm_pkg::REQ_TRIGGER: cmd_o.trig_en   = 1'b1;
            svm_pkg::REQ_WRITE:   cmd_o.write_en  = 1'b1;
            svm_pkg::REQ_TICK:    cmd_o.clear_acc = 1'b1;
            default:              cmd_o           = '0;
          endcase
        end
      end
      svm_pkg::ST_MIX:    cmd_o.issue_en = 1'b1;
      svm_pkg::ST_FINISH: cmd_o.load_out = out_free_i;
      default:            cmd_o          = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svm_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Requests are taken only while idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> state_q == svm_pkg::ST_IDLE)
    else $error("request taken outside idle");

  // A frame walks every voice once before draining
  a_mix_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svm_pkg::ST_MIX && !last_voice) |=> state_q == svm_pkg::ST_MIX)
    else $error("mix left early");

  // The result is captured only when the output stage can take it
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free_i && state_q == svm_pkg::ST_FINISH)
    else $error("result loaded while output busy");

endmodule

`default_nettype wire

FILE: sv/svm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module svm_datapath #(
  parameter int unsigned VOICES = 4,
  parameter int unsigned VW     = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire svm_pkg::svm_cmd_t              cmd_i,
  input  wire logic [VW-1:0]                  voice_i,
  output logic                                out_free_o,
  // Request fields
  input  wire logic [2:0]                     voice_index_i,
  input  wire logic [2:0]                     sound_index_i,
  input  wire logic [svm_pkg::GAIN_W-1:0]     left_volume_i,
  input  wire logic [svm_pkg::GAIN_W-1:0]     right_volume_i,
  input  wire logic [15:0]                    sample_address_i,
  input  wire logic [svm_pkg::SAMPLE_W-1:0]   sample_value_i,
  // Length register writes
  input  wire logic                           cfg_we_i,
  input  wire logic [svm_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  wire logic [svm_pkg::LEN_W-1:0]      cfg_wdata_i,
  // Result
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [svm_pkg::SAMPLE_W-1:0]        left_sample_o,
  output logic [svm_pkg::SAMPLE_W-1:0]        right_sample_o,
  output logic [svm_pkg::MASK_W-1:0]          active_voices_o
);

  localparam int unsigned MW = (VOICES < svm_pkg::MASK_W) ? VOICES : svm_pkg::MASK_W;
  localparam int unsigned MEM_WORDS = svm_pkg::SOUNDS * svm_pkg::SOUND_WORDS;

  // Voice state
  logic [VOICES-1:0]             active_q;
  logic [svm_pkg::SND_W-1:0]     sound_q [VOICES];
  logic [svm_pkg::POS_W-1:0]     pos_q   [VOICES];
  logic [svm_pkg::GAIN_W-1:0]    gl_q    [VOICES];
  logic [svm_pkg::GAIN_W-1:0]    gr_q    [VOICES];
  logic [svm_pkg::LEN_W-1:0]     len_q   [svm_pkg::SOUNDS];

  // Sample memory
  logic [svm_pkg::SAMPLE_W-1:0]  mem [MEM_WORDS];

  // Pipeline
  logic                          v1_q, v2_q;
  logic [svm_pkg::SAMPLE_W-1:0]  rdata_q;
  logic [svm_pkg::GAIN_W-1:0]    gain_l_q, gain_r_q;
  logic [svm_pkg::SAMPLE_W-1:0]  prod_l_q, prod_r_q;
  logic [svm_pkg::SAMPLE_W-1:0]  acc_l_q, acc_r_q;

  // Output stage
  logic                          out_valid_q;
  logic [svm_pkg::SAMPLE_W-1:0]  out_l_q, out_r_q;
  logic [svm_pkg::MASK_W-1:0]    out_mask_q;

  logic                          trig_ok;
  logic [VW-1:0]                 trig_sel;
  logic [svm_pkg::SND_W-1:0]     snd;
  logic [svm_pkg::LEN_W-1:0]     len_raw, len_clip;
  logic [svm_pkg::POS_W-1:0]     pos;
  logic                          hit;
  logic [svm_pkg::MEM_AW-1:0]    raddr, waddr;
  logic signed [svm_pkg::PROD_W-1:0] mul_l, mul_r;

  // Decode trigger
  assign trig_ok  = cmd_i.trig_en && (32'(voice_index_i) < VOICES) &&
                    (32'(sound_index_i) < svm_pkg::SOUNDS);
  assign trig_sel = VW'(voice_index_i);

  // Look up the issued voice: clip length to region size, check for end
  always_comb begin
    snd      = sound_q[voice_i];
    len_raw  = len_q[snd];
    len_clip = (len_raw > svm_pkg::LEN_W'(svm_pkg::SOUND_WORDS)) ?
               svm_pkg::LEN_W'(svm_pkg::SOUND_WORDS) : len_raw;
    pos      = pos_q[voice_i];
    hit      = active_q[voice_i] && (pos < len_clip);
    raddr    = {snd, pos[svm_pkg::OFS_W-1:0]};
    waddr    = sample_address_i[svm_pkg::MEM_AW-1:0];
  end

  // Length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < svm_pkg::SOUNDS; i++) len_q[i] <= '0;
    end else if (cfg_we_i && (32'(cfg_addr_i) < svm_pkg::SOUNDS)) begin
      len_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  // Voice state: restart on trigger, advance or stop on issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < VOICES; i++) begin
        sound_q[i] <= '0;
        pos_q[i]   <= '0;
        gl_q[i]    <= '0;
        gr_q[i]    <= '0;
      end
    end else if (trig_ok) begin
      active_q[trig_sel] <= 1'b1;
      sound_q[trig_sel]  <= svm_pkg::SND_W'(sound_index_i);
      pos_q[trig_sel]    <= '0;
      gl_q[trig_sel]     <= left_volume_i;
      gr_q[trig_sel]     <= right_volume_i;
    end else if (cmd_i.issue_en && active_q[voice_i]) begin
      if (hit) begin
        pos_q[voice_i] <= pos + svm_pkg::POS_W'(1);
      end else begin
        active_q[voice_i] <= 1'b0;
      end
    end
  end

  // Sample memory: one write or one read a cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en) begin
      mem[waddr] <= sample_value_i;
    end
    if (cmd_i.issue_en) begin
      rdata_q  <= mem[raddr];
      gain_l_q <= gl_q[voice_i];
      gain_r_q <= gr_q[voice_i];
    end
  end

  // Scale: signed sample times unsigned gain, arithmetic shift right by 8
  assign mul_l = $signed(rdata_q) * $signed({1'b0, gain_l_q});
  assign mul_r = $signed(rdata_q) * $signed({1'b0, gain_r_q});

  always_ff @(posedge clk_i) begin
    prod_l_q <= mul_l[svm_pkg::SAMPLE_W+7:8];
    prod_r_q <= mul_r[svm_pkg::SAMPLE_W+7:8];
  end

  // Stage valids and wrapping accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else begin
      v1_q <= cmd_i.issue_en && hit;
      v2_q <= v1_q;
      if (cmd_i.clear_acc) begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end else if (v2_q) begin
        acc_l_q <= acc_l_q + prod_l_q;
        acc_r_q <= acc_r_q + prod_r_q;
      end
    end
  end

  // Output register: hold the frame until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_l_q    <= acc_l_q;
      out_r_q    <= acc_r_q;
      out_mask_q <= svm_pkg::MASK_W'(active_q[MW-1:0]);
    end
  end

  assign out_free_o      = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign left_sample_o   = out_l_q;
  assign right_sample_o  = out_r_q;
  assign active_voices_o = out_mask_q;

  // The frame is captured only after the last product has been summed
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !v1_q && !v2_q)
    else $error("result captured with products in flight");

  // A valid trigger restarts its voice at position zero
  a_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_ok |=> active_q[$past(trig_sel)] && pos_q[$past(trig_sel)] == '0)
    else $error("trigger did not restart voice");

  // Voice 0 never walks past the end of its region
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[0] <= svm_pkg::POS_W'(svm_pkg::SOUND_WORDS))
    else $error("voice position beyond region");

endmodule

`default_nettype wire

FILE: sv/sample_voice_mixer.sv
// Four-voice stereo sample mixer. Requests arrive on the slave stream with the request
// kind on tuser: trigger restarts one voice on one sound region at position zero with
// left and right gains in unsigned Q1.8, write stores one 16-bit sample into sample
// memory, and tick mixes one stereo frame that leaves on the master stream together with
// the mask of voices still playing. No request is taken while a tick is in progress: the
// single-port sample memory is read once per voice, one voice a cycle, followed by the
// multiply and accumulate stages and the capture into the output register. A finished
// frame waits in the output register while triggers and writes continue; the next frame
// waits only if the previous one is still untaken. Lengths of the sound regions are set
// through the length register port, registers 0 to 3; the user must write them only
// while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module sample_voice_mixer #(
  parameter int unsigned VOICES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // voice_index[2:0], sound_index[5:3], left_volume[14:6], right_volume[23:15],
  // sample_address[39:24], sample_value[55:40]
  input  wire logic [55:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Frame stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // left_sample[15:0], right_sample[31:16], active_voices[35:32], zero[39:36]
  output logic [39:0]      m_axis_tdata,
  // Length registers
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [14:0] cfg_wdata_i
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  svm_pkg::svm_cmd_t             cmd;
  logic [VW-1:0]                 voice;
  logic                          out_free;
  logic [svm_pkg::SAMPLE_W-1:0]  left_sample, right_sample;
  logic [svm_pkg::MASK_W-1:0]    active_voices;

  svm_ctrl #(
    .VOICES (VOICES),
    .VW     (VW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_type_i  (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .out_free_i  (out_free),
    .cmd_o       (cmd),
    .voice_o     (voice)
  );

  svm_datapath #(
    .VOICES (VOICES),
    .VW     (VW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .voice_i          (voice),
    .out_free_o       (out_free),
    .voice_index_i    (s_axis_tdata[2:0]),
    .sound_index_i    (s_axis_tdata[5:3]),
    .left_volume_i    (s_axis_tdata[14:6]),
    .right_volume_i   (s_axis_tdata[23:15]),
    .sample_address_i (s_axis_tdata[39:24]),
    .sample_value_i   (s_axis_tdata[55:40]),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .left_sample_o    (left_sample),
    .right_sample_o   (right_sample),
    .active_voices_o  (active_voices)
  );

  assign m_axis_tdata = {4'b0000, active_voices, right_sample, left_sample};

endmodule

`default_nettype wire
